/* rtl/core/crcfa_pkg.sv */
// Shared types, constants and the CRC-16 byte fold for the CRC frame engine.
// No dependencies; imported by every module of the block except crcfa_checker.
`default_nettype none

package crcfa_pkg;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [1:0]  CntSat  = 2'd3;

  typedef enum logic [1:0] {
    CMD_ECHO,
    CMD_ECHO_CRC,
    CMD_VERDICT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;
    logic [15:0] crc;
    logic        good;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/crcfa_front.sv */
// Front end: takes input bytes, runs the CRC and verify bookkeeping, issues commands.
// Depends on crcfa_pkg.
`default_nettype none

module crcfa_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire                  cfg_wdata_i,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire [7:0]            in_byte_i,
  input  wire                  in_last_i,
  input  crcfa_pkg::q_stat_t   q_stat_i,
  output logic                 push_o,
  output crcfa_pkg::cmd_t      cmd_o
);
  import crcfa_pkg::*;

  logic        verify_q;
  logic [15:0] crc_q;
  logic [7:0]  held0_q, held1_q;
  logic [1:0]  cnt_q;

  logic        accept;
  logic [15:0] crc_byte, crc_held, crc_v;
  logic [1:0]  cnt_v;
  logic        good;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  assign crc_byte = crc_fold(crc_q, in_byte_i);
  assign crc_held = crc_fold(crc_q, held0_q);
  assign crc_v    = (cnt_q >= 2'd2) ? crc_held : crc_q;
  assign cnt_v    = (cnt_q == CntSat) ? CntSat : cnt_q + 2'd1;
  assign good     = (cnt_v == CntSat) && (held1_q == crc_v[7:0]) &&
                    (in_byte_i == crc_v[15:8]);

  always_comb begin
    cmd_o.data = in_byte_i;
    cmd_o.crc  = crc_byte;
    cmd_o.good = good;
    if (verify_q) begin
      cmd_o.kind = CMD_VERDICT;
    end else if (in_last_i) begin
      cmd_o.kind = CMD_ECHO_CRC;
    end else begin
      cmd_o.kind = CMD_ECHO;
    end
  end

  assign push_o = accept && (!verify_q || in_last_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      verify_q <= 1'b0;
    end else if (cfg_we_i) begin
      verify_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CrcInit;
      held0_q <= 8'h00;
      held1_q <= 8'h00;
      cnt_q   <= 2'd0;
    end else if (accept) begin
      if (in_last_i) begin
        crc_q   <= CrcInit;
        held0_q <= 8'h00;
        held1_q <= 8'h00;
        cnt_q   <= 2'd0;
      end else if (verify_q) begin
        crc_q   <= crc_v;
        held0_q <= held1_q;
        held1_q <= in_byte_i;
        cnt_q   <= cnt_v;
      end else begin
        crc_q   <= crc_byte;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/crcfa_fifo.sv */
// Command queue between the front end and the result sequencer.
// Depends on crcfa_pkg.
`default_nettype none

module crcfa_fifo #(
  parameter int Depth = 4
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  crcfa_pkg::cmd_t      cmd_i,
  input  wire                  pop_i,
  output crcfa_pkg::cmd_t      cmd_o,
  output crcfa_pkg::q_stat_t   stat_o
);
  import crcfa_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.full  = (cnt_q == CntFull);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && stat_o.valid;
  assign cmd_o        = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/crcfa_back.sv */
// Result sequencer: expands queued commands into result items in an output register.
// Depends on crcfa_pkg.
`default_nettype none

module crcfa_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  crcfa_pkg::q_stat_t   q_stat_i,
  input  crcfa_pkg::cmd_t      cmd_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 out_last_o,
  output logic                 is_verdict_o,
  output logic                 crc_good_o
);
  import crcfa_pkg::*;

  localparam logic [1:0] PhEcho  = 2'd0;
  localparam logic [1:0] PhCrcLo = 2'd1;
  localparam logic [1:0] PhCrcHi = 2'd2;

  logic       valid_q;
  logic [1:0] phase_q, phase_d;
  logic       load, done;
  logic [7:0] byte_d;
  logic       last_d, verdict_d, good_d;

  assign load = q_stat_i.valid && (!valid_q || out_ready_i);

  always_comb begin
    byte_d    = cmd_i.data;
    last_d    = 1'b0;
    verdict_d = 1'b0;
    good_d    = 1'b0;
    done      = 1'b1;
    phase_d   = PhEcho;
    unique case (cmd_i.kind)
      CMD_ECHO: begin
      end
      CMD_ECHO_CRC: begin
        unique case (phase_q)
          PhEcho: begin
            done    = 1'b0;
            phase_d = PhCrcLo;
          end
          PhCrcLo: begin
            byte_d  = cmd_i.crc[7:0];
            done    = 1'b0;
            phase_d = PhCrcHi;
          end
          default: begin
            byte_d = cmd_i.crc[15:8];
            last_d = 1'b1;
          end
        endcase
      end
      CMD_VERDICT: begin
        byte_d    = 8'h00;
        last_d    = 1'b1;
        verdict_d = 1'b1;
        good_d    = cmd_i.good;
      end
      default: begin
      end
    endcase
  end

  assign pop_o = load && done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= PhEcho;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        phase_q <= phase_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_o   <= byte_d;
      out_last_o   <= last_d;
      is_verdict_o <= verdict_d;
      crc_good_o   <= good_d;
    end
  end

  assign out_valid_o = valid_q;

endmodule

`default_nettype wire

/* rtl/core/crc16_frame_append_verify.sv */
// Top level of the CRC-16 frame engine: front end, command queue, result sequencer.
// Depends on crcfa_pkg, crcfa_front, crcfa_fifo, crcfa_back.
//
//   channel | handshake          | payload
//   --------+--------------------+----------------------------------------------
//   in      | in_valid/in_ready  | in_byte_i, in_last_i
//   out     | out_valid/out_ready| out_byte_o, out_last_o, is_verdict_o, crc_good_o
//   cfg     | cfg_we_i           | cfg_wdata_i (verify_mode)
//
// One byte is taken per cycle while the command queue is not full; the CRC fold of a byte is combinational logic.
// Results leave one per cycle while out_ready_i is high; a last byte in append mode makes
// three results, so the output side sets the long-run rate.
// Each result passes through the command queue and then the output register after its byte is taken.
// Input stalls only when the command queue (QueueDepth entries) is full.
// Reset is asynchronous and active low; it clears mode, CRC state and queue.
`default_nettype none

module crc16_frame_append_verify #(
  parameter int QueueDepth = 4
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire        cfg_wdata_i,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire  [7:0] in_byte_i,
  input  wire        in_last_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       is_verdict_o,
  output logic       crc_good_o
);
  import crcfa_pkg::*;

  cmd_t    push_cmd, head_cmd;
  logic    push, pop;
  q_stat_t q_stat;

  crcfa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  crcfa_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (q_stat)
  );

  crcfa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_stat_i     (q_stat),
    .cmd_i        (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o),
    .is_verdict_o (is_verdict_o),
    .crc_good_o   (crc_good_o)
  );

endmodule

`default_nettype wire

/* rtl/core/crcfa_checker.sv */
// Port-level checks on the CRC frame engine's result channel, and their bind.
// Depends on crc16_frame_append_verify's port list.
`default_nettype none

module crcfa_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       out_valid_o,
  input wire       out_ready_i,
  input wire [7:0] out_byte_o,
  input wire       out_last_o,
  input wire       is_verdict_o,
  input wire       crc_good_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) &&
      $stable(out_last_o) && $stable(is_verdict_o) && $stable(crc_good_o))
    else $error("result changed while stalled");

  a_verdict_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_verdict_o |-> out_last_o)
    else $error("verdict not marked last");

  a_verdict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_verdict_o |-> out_byte_o == 8'h00)
    else $error("verdict carries a nonzero byte");

  a_good_only_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_verdict_o |-> !crc_good_o)
    else $error("good flag on a data result");

endmodule

bind crc16_frame_append_verify crcfa_checker u_crcfa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_byte_o   (out_byte_o),
  .out_last_o   (out_last_o),
  .is_verdict_o (is_verdict_o),
  .crc_good_o   (crc_good_o)
);

`default_nettype wire
